// ===== rtl/frr_pkg.sv =====
// Shared types and constants for the right-angle frame rotator.
// Used by frr_ctrl, frr_datapath and frame_rotate_right_angle; depends on nothing.
`timescale 1ns / 1ps

package frr_pkg;

    localparam int MAX_WIDTH    = 64;
    localparam int MAX_HEIGHT   = 64;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_DIM      = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;

    // Field and register widths.
    localparam int SAMPLE_W = 8;
    localparam int SIZE_W   = 7;
    localparam int CHCNT_W  = 3;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    // Internal widths.
    localparam int DIM_W    = $clog2(MAX_DIM);
    localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LIN_W    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int PROD1_W  = DIM_W + SIZE_W;
    localparam int PROD2_W  = LIN_W + CHCNT_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd3;

    // Rotation modes.
    localparam logic [MODE_W-1:0] MODE_ROT90  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROT180 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROT270 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALIAS  = 2'd3;

    // Input commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Controller to datapath.
    typedef struct packed {
        logic ready;
        logic mul;
        logic addr;
        logic rd;
        logic load_out;
    } frr_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic read_start;
        logic out_free;
    } frr_status_t;

endpackage

// ===== rtl/frr_ctrl.sv =====
// Sequencer for the read path of the frame rotator.
// Depends on frr_pkg for the command and status structs.
`timescale 1ns / 1ps

module frr_ctrl
    import frr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frr_status_t status,
    output frr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_READ,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.read_start)
                begin
                    state_next = ST_MUL;
                    ready_next = 1'b0;
                end
            end
            ST_MUL:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_READ;
            ST_READ: state_next = ST_OUT;
            ST_OUT:
            begin
                // The result waits here until the output register is free.
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    always_comb
    begin
        cmd.ready    = ready_reg;
        cmd.mul      = (state_reg == ST_MUL);
        cmd.addr     = (state_reg == ST_ADDR);
        cmd.rd       = (state_reg == ST_READ);
        cmd.load_out = (state_reg == ST_OUT) && status.out_free;
    end

endmodule

// ===== rtl/frr_datapath.sv =====
// Datapath of the frame rotator: registers, counters, frame store, address pipeline
// and output register. Depends on frr_pkg; sequenced by frr_ctrl.
`timescale 1ns / 1ps

module frr_datapath
    import frr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic [SAMPLE_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tready,
    input  frr_cmd_t              cmd,
    output frr_status_t           status,
    output logic                  m_tvalid,
    output logic [SAMPLE_W-1:0]   m_tdata,
    output logic                  m_tlast
);

    // Configuration registers.
    logic [MODE_W-1:0]  mode_reg;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [CHCNT_W-1:0] chans_reg;

    // Effective sizes.
    logic [SIZE_W-1:0]  w_eff, h_eff, ow, oh;
    logic [CHCNT_W-1:0] ch_eff;
    logic [MODE_W-1:0]  mode_eff;

    // Load and read counters.
    logic               ready_reg;
    logic [ADDR_W-1:0]  ld_addr_reg;
    logic [DIM_W-1:0]   ld_row_reg, ld_col_reg;
    logic [CH_W-1:0]    ld_chan_reg;
    logic [DIM_W-1:0]   out_row_reg, out_col_reg;
    logic [CH_W-1:0]    out_chan_reg;

    // Address pipeline.
    logic [DIM_W-1:0]   r_reg, c_reg;
    logic [CH_W-1:0]    chan_reg;
    logic               last_reg;
    logic [LIN_W-1:0]   lin_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [SAMPLE_W-1:0] rdata_reg;

    // Output register.
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic                out_last_reg;

    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];

    logic accept, write_go, read_go, load_done, last_next;
    logic [SIZE_W-1:0] r_full, c_full;
    logic [PROD1_W-1:0] prod1;
    logic [PROD2_W-1:0] prod2;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = SIZE_W'(1);
        else if (width_reg > SIZE_W'(MAX_WIDTH))
            w_eff = SIZE_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = SIZE_W'(1);
        else if (height_reg > SIZE_W'(MAX_HEIGHT))
            h_eff = SIZE_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;

        if (chans_reg == '0)
            ch_eff = CHCNT_W'(1);
        else if (chans_reg > CHCNT_W'(MAX_CHANNELS))
            ch_eff = CHCNT_W'(MAX_CHANNELS);
        else
            ch_eff = chans_reg;

        mode_eff = (mode_reg == MODE_ALIAS) ? MODE_ROT90 : mode_reg;
        ow = (mode_eff == MODE_ROT180) ? w_eff : h_eff;
        oh = (mode_eff == MODE_ROT180) ? h_eff : w_eff;
    end

    assign accept   = s_tvalid && cmd.ready;
    assign write_go = accept && (s_tuser == CMD_WRITE) && !ready_reg;
    assign read_go  = accept && (s_tuser == CMD_READ) && ready_reg;

    assign load_done = (ld_chan_reg == CH_W'(ch_eff - CHCNT_W'(1)))
                    && ({1'b0, ld_col_reg} == w_eff - SIZE_W'(1))
                    && ({1'b0, ld_row_reg} == h_eff - SIZE_W'(1));

    assign last_next = (out_chan_reg == CH_W'(ch_eff - CHCNT_W'(1)))
                    && ({1'b0, out_col_reg} == ow - SIZE_W'(1))
                    && ({1'b0, out_row_reg} == oh - SIZE_W'(1));

    // Source pixel of the next output sample.
    always_comb
    begin
        case (mode_eff)
            MODE_ROT180:
            begin
                r_full = h_eff - SIZE_W'(1) - SIZE_W'(out_row_reg);
                c_full = w_eff - SIZE_W'(1) - SIZE_W'(out_col_reg);
            end
            MODE_ROT270:
            begin
                r_full = SIZE_W'(out_col_reg);
                c_full = w_eff - SIZE_W'(1) - SIZE_W'(out_row_reg);
            end
            default:
            begin
                r_full = h_eff - SIZE_W'(1) - SIZE_W'(out_col_reg);
                c_full = SIZE_W'(out_row_reg);
            end
        endcase
    end

    assign prod1 = PROD1_W'(r_reg) * PROD1_W'(w_eff);
    assign prod2 = PROD2_W'(lin_reg) * PROD2_W'(ch_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ROT90;
            width_reg    <= SIZE_W'(64);
            height_reg   <= SIZE_W'(64);
            chans_reg    <= CHCNT_W'(1);
            ready_reg    <= 1'b0;
            ld_addr_reg  <= '0;
            ld_row_reg   <= '0;
            ld_col_reg   <= '0;
            ld_chan_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_chan_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:     mode_reg   <= cfg_wdata[MODE_W-1:0];
                REG_WIDTH:    width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_HEIGHT:   height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_CHANNELS: chans_reg  <= cfg_wdata[CHCNT_W-1:0];
                default:      mode_reg   <= mode_reg;
            endcase
            // Any register write restarts the frame; the store keeps its contents.
            ready_reg    <= 1'b0;
            ld_addr_reg  <= '0;
            ld_row_reg   <= '0;
            ld_col_reg   <= '0;
            ld_chan_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_chan_reg <= '0;
        end
        else if (write_go)
        begin
            if (load_done)
            begin
                ready_reg   <= 1'b1;
                ld_addr_reg <= '0;
                ld_row_reg  <= '0;
                ld_col_reg  <= '0;
                ld_chan_reg <= '0;
            end
            else
            begin
                ld_addr_reg <= ld_addr_reg + ADDR_W'(1);
                if (ld_chan_reg != CH_W'(ch_eff - CHCNT_W'(1)))
                    ld_chan_reg <= ld_chan_reg + CH_W'(1);
                else
                begin
                    ld_chan_reg <= '0;
                    if ({1'b0, ld_col_reg} != w_eff - SIZE_W'(1))
                        ld_col_reg <= ld_col_reg + DIM_W'(1);
                    else
                    begin
                        ld_col_reg <= '0;
                        ld_row_reg <= ld_row_reg + DIM_W'(1);
                    end
                end
            end
        end
        else if (read_go)
        begin
            if (last_next)
            begin
                ready_reg    <= 1'b0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                out_chan_reg <= '0;
            end
            else if (out_chan_reg != CH_W'(ch_eff - CHCNT_W'(1)))
                out_chan_reg <= out_chan_reg + CH_W'(1);
            else
            begin
                out_chan_reg <= '0;
                if ({1'b0, out_col_reg} != ow - SIZE_W'(1))
                    out_col_reg <= out_col_reg + DIM_W'(1);
                else
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + DIM_W'(1);
                end
            end
        end
    end

    // Address pipeline: pixel coordinates, row-major pixel index, sample address.
    always_ff @(posedge clk)
    begin
        if (read_go)
        begin
            r_reg    <= r_full[DIM_W-1:0];
            c_reg    <= c_full[DIM_W-1:0];
            chan_reg <= out_chan_reg;
            last_reg <= last_next;
        end
        if (cmd.mul)
            lin_reg <= LIN_W'(prod1 + PROD1_W'(c_reg));
        if (cmd.addr)
            addr_reg <= ADDR_W'(prod2 + PROD2_W'(chan_reg));
    end

    always_ff @(posedge clk)
    begin
        if (write_go)
            mem[ld_addr_reg] <= s_tdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
            rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= rdata_reg;
            out_last_reg <= last_reg;
        end
    end

    assign status.read_start = read_go;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // A waiting result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while a result waits");

    // While the frame is ready the read counters stay inside the rotated frame.
    a_read_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> ((CHCNT_W'(out_chan_reg) < ch_eff)
                    && (SIZE_W'(out_col_reg) < ow)
                    && (SIZE_W'(out_row_reg) < oh)))
        else $error("read counters left the rotated frame");

    // Reading the last sample returns the block to loading.
    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (read_go && last_next && !cfg_we) |=> !ready_reg)
        else $error("block stayed in the read phase after the last sample");

endmodule

// ===== rtl/frame_rotate_right_angle.sv =====
// Top level of the right-angle frame rotator (90, 180 and 270 degrees clockwise).
// Write transactions load the frame store at one per cycle and can follow back to back.
// A read passes the two-multiply address pipeline (coordinate, pixel index, sample address
// registers) and the registered frame store read, then loads the output register.
// A stalled output holds the sequencer in its last step; writes are not taken meanwhile.
// Reset (rst_n, asynchronous) restores default registers; the frame store is not cleared.
`timescale 1ns / 1ps

module frame_rotate_right_angle
    import frr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [7:0] sample_in
    input  logic [0:0]            s_tuser,   // [0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [7:0] sample_out
    output logic                  m_tlast
);

    frr_cmd_t    cmd;
    frr_status_t status;

    frr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    frr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser[0]),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    assign s_tready = cmd.ready;

endmodule
